[hw/rtl/metc_pkg.sv]
// Shared constants, types and codes for the escape-time colorizer.
package metc_pkg;

    // Datapath defaults
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int IN_FRAC         = 28;   // fraction bits of c on the input bus

    // Bus widths
    localparam int C_WIDTH      = 32;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 24;
    localparam int ESC_CNT_W    = 16;
    localparam int PAL_W        = 8;

    // Configuration registers
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int MAX_ITER_W   = 16;
    localparam int COLOR_CNT_W  = 8;
    localparam logic [MAX_ITER_W-1:0]  MAX_ITER_RST  = 16'd500;
    localparam logic [COLOR_CNT_W-1:0] COLOR_CNT_RST = 8'd60;

    // Register index = paddr[2]
    localparam logic REG_MAX_ITER  = 1'b0;
    localparam logic REG_COLOR_CNT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MAG,
        ST_MUL_XY,
        ST_UPDATE,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_FINISH
    } metc_state_t;

    typedef enum logic [1:0] {
        MSEL_XX,
        MSEL_YY,
        MSEL_XY
    } metc_msel_t;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        metc_msel_t mul_sel;
        logic       cap_xx;
        logic       cap_yy;
        logic       cap_xy;
        logic       update;
        logic       set_inside;
        logic       mod_start;
        logic       out_load;
    } metc_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic big;
        logic mag_escape;
        logic mul_done;
        logic mod_done;
        logic out_free;
    } metc_status_t;

endpackage

[hw/rtl/metc_mul.sv]
// Limb-serial unsigned multiplier: one 32x32 partial product per cycle.
module metc_mul
    import metc_pkg::*;
#(
    parameter int MW = DEF_FRAC_BITS + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MW-1:0]     a,
    input  logic [MW-1:0]     b,
    output logic              done,
    output logic [2*MW-1:0]   prod
);

    localparam int L  = (MW + 31) / 32;
    localparam int AW = 32 * L;
    localparam int IW = (L > 1) ? $clog2(L) : 1;

    logic [AW-1:0]   a_reg, b_reg;
    logic [2*AW-1:0] acc_reg;
    logic [IW-1:0]   i_reg, j_reg;
    logic            busy_reg, done_reg;

    logic [31:0]     a_limb, b_limb;
    logic [63:0]     partial;
    logic [IW:0]     shamt;
    logic [2*AW-1:0] addend;
    logic            last;

    always_comb
    begin
        a_limb  = a_reg[i_reg*32 +: 32];
        b_limb  = b_reg[j_reg*32 +: 32];
        partial = a_limb * b_limb;
        shamt   = (IW+1)'(i_reg) + (IW+1)'(j_reg);
        addend  = (2*AW)'(partial) << {shamt, 5'd0};
        last    = (i_reg == IW'(L-1)) && (j_reg == IW'(L-1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (j_reg == IW'(L-1))
            begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= AW'(a);
            b_reg   <= AW'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[2*MW-1:0];

endmodule

[hw/rtl/metc_ctrl.sv]
// Sequencer for the escape-time iteration, modulo and result handoff.
module metc_ctrl
    import metc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  metc_status_t status,
    output logic         in_ready,
    output metc_cmd_t    cmd
);

    metc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MSEL_XX;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.at_limit)
                begin
                    cmd.set_inside = 1'b1;
                    state_next     = ST_MOD_START;
                end
                else if (status.big)
                begin
                    state_next = ST_MOD_START;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_XX;
                    state_next    = ST_MUL_XX;
                end
            end
            ST_MUL_XX:
            begin
                if (status.mul_done)
                begin
                    cmd.cap_xx    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_YY;
                    state_next    = ST_MUL_YY;
                end
            end
            ST_MUL_YY:
            begin
                if (status.mul_done)
                begin
                    cmd.cap_yy = 1'b1;
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (status.mag_escape)
                begin
                    state_next = ST_MOD_START;
                end
                else
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MSEL_XY;
                    state_next    = ST_MUL_XY;
                end
            end
            ST_MUL_XY:
            begin
                if (status.mul_done)
                begin
                    cmd.cap_xy = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_MOD_START:
            begin
                cmd.mod_start = 1'b1;
                state_next    = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (status.mod_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/metc_dp.sv]
// Datapath: z registers, shared multiplier, serial modulo and output register.
module metc_dp
    import metc_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  metc_cmd_t                     cmd,
    output metc_status_t                  status,
    input  logic signed [C_WIDTH-1:0]     c_real,
    input  logic signed [C_WIDTH-1:0]     c_imag,
    input  logic [MAX_ITER_W-1:0]         max_iterations,
    input  logic [COLOR_CNT_W-1:0]        color_count,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ESC_CNT_W-1:0]          escape_count,
    output logic                          inside_res,
    output logic [PAL_W-1:0]              palette_index
);

    localparam int ZW  = FRAC_BITS + 6;   // z and c, |value| < 16
    localparam int MW  = FRAC_BITS + 1;   // operand magnitude, |z| < 2
    localparam int PRW = FRAC_BITS + 2;   // scaled product, < 4
    localparam int MCW = $clog2(COUNT_WIDTH);
    localparam logic signed [ZW-1:0] TWO     = ZW'(1) << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
    localparam logic [PRW:0]         FOUR    = (PRW+1)'(1) << PRW;

    logic signed [ZW-1:0] cr_in, ci_in;
    logic signed [ZW-1:0] cr_reg, ci_reg, x_reg, y_reg;
    logic signed [ZW-1:0] x_abs, y_abs, x_next, y_next, xy2;
    logic [PRW-1:0]       xx_reg, yy_reg, xy_reg, prod_scaled;
    logic [COUNT_WIDTH-1:0] count_reg, limit;
    logic                 inside_reg;

    logic [MW-1:0]        mul_a, mul_b;
    logic [2*MW-1:0]      mul_prod;
    logic                 mul_done;

    logic [COUNT_WIDTH-1:0] div_reg;
    logic [PAL_W-1:0]     rem_reg;
    logic [PAL_W:0]       rem9;
    logic [MCW-1:0]       mcnt_reg;
    logic                 mod_busy_reg, mod_done_reg;

    logic                 out_valid_reg;
    logic [ESC_CNT_W-1:0] out_cnt_reg;
    logic                 out_inside_reg;
    logic [PAL_W-1:0]     out_pal_reg;
    logic [PAL_W-1:0]     pal;

    // Input format conversion to FRAC_BITS fraction bits
    generate
        if (FRAC_BITS >= IN_FRAC)
        begin : g_up
            localparam int SH_UP = FRAC_BITS - IN_FRAC;
            assign cr_in = ZW'(c_real) <<< SH_UP;
            assign ci_in = ZW'(c_imag) <<< SH_UP;
        end
        else
        begin : g_dn
            // truncate toward zero: shift the magnitude, reapply sign
            localparam int SH_DN = IN_FRAC - FRAC_BITS;
            logic signed [C_WIDTH:0] cr_ext, ci_ext;
            logic [C_WIDTH:0]        cr_mag, ci_mag, cr_sh, ci_sh;
            always_comb
            begin
                cr_ext = (C_WIDTH+1)'(c_real);
                ci_ext = (C_WIDTH+1)'(c_imag);
                cr_mag = cr_ext[C_WIDTH] ? -cr_ext : cr_ext;
                ci_mag = ci_ext[C_WIDTH] ? -ci_ext : ci_ext;
                cr_sh  = cr_mag >> SH_DN;
                ci_sh  = ci_mag >> SH_DN;
                cr_in  = ZW'(cr_ext[C_WIDTH] ? -cr_sh : cr_sh);
                ci_in  = ZW'(ci_ext[C_WIDTH] ? -ci_sh : ci_sh);
            end
        end
    endgenerate

    always_comb
    begin
        x_abs       = x_reg[ZW-1] ? -x_reg : x_reg;
        y_abs       = y_reg[ZW-1] ? -y_reg : y_reg;
        prod_scaled = PRW'(mul_prod >> FRAC_BITS);
        limit       = COUNT_WIDTH'(max_iterations);
        x_next      = signed'(ZW'(xx_reg)) - signed'(ZW'(yy_reg)) + cr_reg;
        xy2         = signed'(ZW'({xy_reg, 1'b0}));
        y_next      = ((x_reg[ZW-1] ^ y_reg[ZW-1]) ? -xy2 : xy2) + ci_reg;
        case (cmd.mul_sel)
            MSEL_XX:
            begin
                mul_a = MW'(x_abs);
                mul_b = MW'(x_abs);
            end
            MSEL_YY:
            begin
                mul_a = MW'(y_abs);
                mul_b = MW'(y_abs);
            end
            MSEL_XY:
            begin
                mul_a = MW'(x_abs);
                mul_b = MW'(y_abs);
            end
            default:
            begin
                mul_a = MW'(x_abs);
                mul_b = MW'(x_abs);
            end
        endcase
    end

    metc_mul #(
        .MW (MW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Iteration state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= cr_in;
            ci_reg <= ci_in;
            x_reg  <= '0;
            y_reg  <= '0;
        end
        else if (cmd.update)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        if (cmd.cap_xx)
        begin
            xx_reg <= prod_scaled;
        end
        if (cmd.cap_yy)
        begin
            yy_reg <= prod_scaled;
        end
        if (cmd.cap_xy)
        begin
            xy_reg <= prod_scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg  <= '0;
                inside_reg <= 1'b0;
            end
            else
            begin
                if (cmd.update)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cmd.set_inside)
                begin
                    inside_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring remainder, one count bit per cycle
    assign rem9 = {rem_reg, div_reg[COUNT_WIDTH-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_busy_reg <= 1'b0;
            mod_done_reg <= 1'b0;
            mcnt_reg     <= '0;
        end
        else if (cmd.mod_start)
        begin
            mod_busy_reg <= 1'b1;
            mod_done_reg <= 1'b0;
            mcnt_reg     <= MCW'(COUNT_WIDTH - 1);
        end
        else if (mod_busy_reg)
        begin
            if (mcnt_reg == '0)
            begin
                mod_busy_reg <= 1'b0;
                mod_done_reg <= 1'b1;
            end
            else
            begin
                mcnt_reg <= mcnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            div_reg <= count_reg;
            rem_reg <= '0;
        end
        else if (mod_busy_reg)
        begin
            div_reg <= div_reg << 1;
            if (rem9 >= {1'b0, color_count})
            begin
                rem_reg <= PAL_W'(rem9 - {1'b0, color_count});
            end
            else
            begin
                rem_reg <= rem9[PAL_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (inside_reg)
        begin
            pal = '0;
        end
        else if (color_count == '0)
        begin
            pal = PAL_W'(1);
        end
        else
        begin
            pal = rem_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cnt_reg    <= ESC_CNT_W'(count_reg);
            out_inside_reg <= inside_reg;
            out_pal_reg    <= pal;
        end
    end

    always_comb
    begin
        status.at_limit   = (count_reg >= limit);
        status.big        = (x_reg >= TWO) || (x_reg <= NEG_TWO) ||
                            (y_reg >= TWO) || (y_reg <= NEG_TWO);
        status.mag_escape = ({1'b0, xx_reg} + {1'b0, yy_reg}) >= FOUR;
        status.mul_done   = mul_done;
        status.mod_done   = mod_done_reg;
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid      = out_valid_reg;
    assign escape_count  = out_cnt_reg;
    assign inside_res    = out_inside_reg;
    assign palette_index = out_pal_reg;

endmodule

[hw/rtl/mandelbrot_escape_time_colorizer_unit.sv]
// Top level of the escape-time colorizer: config registers, sequencer, datapath.
//
// One input beat on the s_ channel carries a point c (real and imaginary parts,
// signed Q4.28). The block iterates z = z*z + c from z = 0 until |z|^2 >= 4 or
// the iteration limit is hit, then sends one result beat on the m_ channel:
// escape count and palette index in m_tdata, the inside flag in m_tuser.
// Points are handled one at a time; s_tready is high only while idle.
// Each iteration is paced by the shared 32x32 multiplier, which works on
// L = ceil((FRAC_BITS+1)/32) 32-bit limbs and forms x*x, y*y and x*y in turn;
// after the iterations a serial remainder forms the palette index for the handoff.
// The result sits in an output register; while the receiver stalls the block
// can still take the next beat, but holds its own next result until the
// register frees up. Reset clears the sequencer and output valid and loads
// max_iterations = 500, color_count = 60. Config writes go in over APB
// (max_iterations at 0x0, color_count at 0x4) and are meant for idle time only.
module mandelbrot_escape_time_colorizer_unit
    import metc_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB config port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready,
    // point in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // c_real [31:0], c_imag [63:32]
    // result out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // escape_count [15:0], palette_index [23:16]
    output logic                   m_tuser    // inside_res [0]
);

    logic [MAX_ITER_W-1:0]  max_iter_reg;
    logic [COLOR_CNT_W-1:0] color_cnt_reg;
    logic                   cfg_wr;

    metc_cmd_t              cmd;
    metc_status_t           status;
    logic [ESC_CNT_W-1:0]   escape_count;
    logic                   inside_res;
    logic [PAL_W-1:0]       palette_index;

    // APB: zero wait states, register picked by word address bit
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg  <= MAX_ITER_RST;
            color_cnt_reg <= COLOR_CNT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAX_ITER:  max_iter_reg  <= pwdata[MAX_ITER_W-1:0];
                REG_COLOR_CNT: color_cnt_reg <= pwdata[COLOR_CNT_W-1:0];
                default:       max_iter_reg  <= max_iter_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_ITER:  prdata = CFG_DATA_W'(max_iter_reg);
            REG_COLOR_CNT: prdata = CFG_DATA_W'(color_cnt_reg);
            default:       prdata = '0;
        endcase
    end

    metc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    metc_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .c_real         (s_tdata[C_WIDTH-1:0]),
        .c_imag         (s_tdata[2*C_WIDTH-1:C_WIDTH]),
        .max_iterations (max_iter_reg),
        .color_count    (color_cnt_reg),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .escape_count   (escape_count),
        .inside_res     (inside_res),
        .palette_index  (palette_index)
    );

    assign m_tdata = {palette_index, escape_count};
    assign m_tuser = inside_res;

endmodule

[hw/rtl/metc_checker.sv]
// Port-level checks for the escape-time colorizer, bound to the top level.
module metc_checker
    import metc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // inside points always get palette entry zero
    a_inside_pal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[23:16] == '0)
        else $error("inside point with nonzero palette index");

    // escaped points never use palette entry zero
    a_escape_pal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[23:16] != '0)
        else $error("escaped point with zero palette index");

    // one point in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a point is in flight");

endmodule

bind mandelbrot_escape_time_colorizer_unit metc_checker u_metc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
